// ===== sv/bdre_pkg.sv =====
// shared types and constants of the byte delta run length encoder
`default_nettype none

package bdre_pkg;

    // most results that one input word can cause
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = 2;
    localparam int COUNT_W     = 3;
    localparam int VALUE_W     = 16;

    // kind of one result word
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_RUN  = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    // one result word
    typedef struct packed {
        kind_t                kind;
        logic [VALUE_W-1:0]   value;
        logic                 last;
    } result_t;

    // all results of one input word, slot 0 leaves first
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] slot;
        logic    [COUNT_W-1:0]     count;
    } group_t;

endpackage

`default_nettype wire

// ===== sv/bdre_encode.sv =====
// input register, change tracking state and result group builder
`default_nettype none

module bdre_encode #(
    parameter int OFFSET_WIDTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          in_base,
    input  wire logic [7:0]          in_new,
    input  wire logic                in_final,
    input  wire logic                grp_free,
    output logic                     grp_load,
    output bdre_pkg::group_t         grp
);

    // counter saturates at the smaller of the offset range and 16 bits
    localparam int CNT_W = (OFFSET_WIDTH < 16) ? OFFSET_WIDTH : 16;
    localparam logic [CNT_W-1:0] CNT_LIM = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic             valid_reg;
    logic [7:0]       base_reg;
    logic [7:0]       new_reg;
    logic             final_reg;
    logic             prev_changed_reg;
    logic             prev_changed_next;
    logic [CNT_W-1:0] run_count_reg;
    logic [CNT_W-1:0] run_count_next;
    logic [CNT_W-1:0] cnt_after;
    logic             changed;
    logic [bdre_pkg::COUNT_W-1:0] n;

    // input register takes a word whenever it is empty or handing off
    assign grp_load = valid_reg && grp_free;
    assign in_ready = !valid_reg || grp_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            base_reg  <= in_base;
            new_reg   <= in_new;
            final_reg <= in_final;
        end
    end

    // build the result group and the next state
    always_comb
    begin
        changed = base_reg != new_reg;
        grp     = '0;
        n       = '0;

        if (changed != prev_changed_reg)
        begin
            cnt_after = CNT_ONE;
        end
        else if (run_count_reg != CNT_LIM)
        begin
            cnt_after = run_count_reg + CNT_ONE;
        end
        else
        begin
            cnt_after = run_count_reg;
        end

        // length of the run that this position ends
        if (changed != prev_changed_reg)
        begin
            grp.slot[n[bdre_pkg::SLOT_W-1:0]].kind  = bdre_pkg::KIND_RUN;
            grp.slot[n[bdre_pkg::SLOT_W-1:0]].value = 16'(run_count_reg);
            n = n + 3'd1;
        end

        // changed byte itself
        if (changed)
        begin
            grp.slot[n[bdre_pkg::SLOT_W-1:0]].kind  = bdre_pkg::KIND_BYTE;
            grp.slot[n[bdre_pkg::SLOT_W-1:0]].value = 16'(new_reg);
            n = n + 3'd1;
        end

        // close an open changed run, then mark the end of the object
        if (final_reg)
        begin
            if (changed)
            begin
                grp.slot[n[bdre_pkg::SLOT_W-1:0]].kind  = bdre_pkg::KIND_RUN;
                grp.slot[n[bdre_pkg::SLOT_W-1:0]].value = 16'(cnt_after);
                n = n + 3'd1;
            end
            grp.slot[n[bdre_pkg::SLOT_W-1:0]].kind  = bdre_pkg::KIND_END;
            grp.slot[n[bdre_pkg::SLOT_W-1:0]].value = '0;
            n = n + 3'd1;
        end

        // flag the final result of this word
        if (n != '0)
        begin
            grp.slot[2'(n - 3'd1)].last = 1'b1;
        end
        grp.count = n;

        if (final_reg)
        begin
            prev_changed_next = 1'b0;
            run_count_next    = '0;
        end
        else
        begin
            prev_changed_next = changed;
            run_count_next    = cnt_after;
        end
    end

    // change tracking state advances when the group is handed on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_changed_reg <= 1'b0;
            run_count_reg    <= '0;
        end
        else if (grp_load)
        begin
            prev_changed_reg <= prev_changed_next;
            run_count_reg    <= run_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bdre_serialize.sv =====
// result group register that sends its words one per cycle while out_ready is high
`default_nettype none

module bdre_serialize (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  grp_load,
    input  wire bdre_pkg::group_t      grp,
    output logic                       grp_free,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output bdre_pkg::result_t          out_word
);

    bdre_pkg::result_t [bdre_pkg::MAX_RESULTS-1:0] slot_reg;
    logic [bdre_pkg::COUNT_W-1:0] rem_reg;
    logic [bdre_pkg::SLOT_W-1:0]  idx_reg;
    logic                         fire;

    // current word comes straight from the group register
    assign out_valid = rem_reg != '0;
    assign out_word  = slot_reg[idx_reg];
    assign fire      = out_valid && out_ready;
    assign grp_free  = (rem_reg == '0) || ((rem_reg == 3'd1) && fire);

    // remaining count and read index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            idx_reg <= '0;
        end
        else if (grp_load)
        begin
            rem_reg <= grp.count;
            idx_reg <= '0;
        end
        else if (fire)
        begin
            rem_reg <= rem_reg - 3'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // group payload
    always_ff @(posedge clk)
    begin
        if (grp_load)
        begin
            slot_reg <= grp.slot;
        end
    end

endmodule

`default_nettype wire

// ===== sv/byte_delta_run_length_encoder.sv =====
// top level of the byte delta run length encoder
//
// channel  dir  tdata                       tuser   tlast
// s_axis   in   [7:0] base, [15:8] new      -       final byte of object
// m_axis   out  [15:0] value                kind    last result of word
//
// a word goes through the input register and is turned into a group of
// zero to four results by combinational logic; results leave one per cycle
// while m_axis is not stalled. the first result shows after its word has
// passed the input register and then the group register of the output stage.
// rst_n clears the change mark, the run counter and all valid flags at once.
// the input register takes a new word while the previous group drains, and a
// stall on m_axis holds the current result unchanged.
`default_nettype none

module byte_delta_run_length_encoder #(
    parameter int OFFSET_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] base_byte, [15:8] new_byte
    input  wire logic        s_axis_tlast,   // final_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] value
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast    // last_of_item
);

    logic              grp_free;
    logic              grp_load;
    bdre_pkg::group_t  grp;
    bdre_pkg::result_t out_word;

    // encoder stage
    bdre_encode #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_encode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_base  (s_axis_tdata[7:0]),
        .in_new   (s_axis_tdata[15:8]),
        .in_final (s_axis_tlast),
        .grp_free (grp_free),
        .grp_load (grp_load),
        .grp      (grp)
    );

    // output stage
    bdre_serialize u_serialize (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_load  (grp_load),
        .grp       (grp),
        .grp_free  (grp_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = out_word.value;
    assign m_axis_tuser = out_word.kind;
    assign m_axis_tlast = out_word.last;

endmodule

`default_nettype wire

// ===== sv/bdre_checker.sv =====
// port level checks of the byte delta run length encoder and their binding
`default_nettype none

module bdre_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // end marker carries zero and closes its word's results
    a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == bdre_pkg::KIND_END) |->
            (m_axis_tdata == 16'd0) && m_axis_tlast)
        else $error("end marker malformed");

    // a changed byte fits in eight bits
    a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == bdre_pkg::KIND_BYTE) |->
            (m_axis_tdata[15:8] == 8'd0))
        else $error("changed byte out of range");

    // after an end marker is taken the next result is not a changed byte
    a_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && (m_axis_tuser == bdre_pkg::KIND_END)
        ##1 m_axis_tvalid |-> (m_axis_tuser != bdre_pkg::KIND_BYTE))
        else $error("changed byte right after end marker");

    // with nothing to send the input side is open
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

endmodule

bind byte_delta_run_length_encoder bdre_checker u_bdre_checker (.*);

`default_nettype wire
